@@ sv/quad_face_area_jacobian_assert.svh @@
// Assertion macros used by the checker of the quad face area block.
// Each macro expects a signal named clk in scope; QFAJ_ASSERT_IMP also rst_n.
`ifndef QUAD_FACE_AREA_JACOBIAN_ASSERT_SVH
`define QUAD_FACE_AREA_JACOBIAN_ASSERT_SVH

// Implication that is checked only while the block is out of reset.
`define QFAJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define QFAJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/qfaj_pkg.sv @@
package qfaj_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;

  // Gauss coordinate register, Q1.15, reset to one over root three.
  localparam int              GAUSS_W     = 16;
  localparam logic [GAUSS_W-1:0] GAUSS_RESET = 16'd18919;

  // Shape derivatives are Q1.17; Jacobian entries are rounded back by this shift.
  localparam int JAC_SHIFT = 17;
  localparam int HALF_LSB  = 15;

  // Area format.
  localparam int AREA_W    = 48;
  localparam int AREA_FRAC = 24;
  localparam int RAD_W     = 2 * AREA_W;

  // Four Gauss points, three coordinates, three minors.
  localparam int NPT  = 4;
  localparam int NCRD = 3;

  // Points with a negative r sign and with a negative s sign, one bit per point.
  localparam logic [NPT-1:0] PT_R_NEG = 4'b1001;
  localparam logic [NPT-1:0] PT_S_NEG = 4'b0011;

  // Register stages in front of the square root, and total latency.
  localparam int PRE_STAGES = 8;
  localparam int LATENCY    = PRE_STAGES + AREA_W + 1;

  // Control that travels alongside the square-root lanes.
  typedef struct packed {
    logic           vld;
    logic [NPT-1:0] sat;
  } qfaj_ctl_t;

  // Coordinate pair that forms each minor.
  function automatic int minor_first(input int m);
    unique case (m)
      0:       minor_first = 0;
      1:       minor_first = 1;
      default: minor_first = 0;
    endcase
  endfunction

  function automatic int minor_second(input int m);
    unique case (m)
      0:       minor_second = 1;
      1:       minor_second = 2;
      default: minor_second = 2;
    endcase
  endfunction

endpackage

@@ sv/qfaj_isqrt.sv @@
module qfaj_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  qfaj_pkg::qfaj_ctl_t            in_ctl,
  input  logic [qfaj_pkg::RAD_W-1:0]     in_rad  [qfaj_pkg::NPT],
  output qfaj_pkg::qfaj_ctl_t            out_ctl,
  output logic [qfaj_pkg::AREA_W-1:0]    out_root [qfaj_pkg::NPT]
);

  localparam int NS    = qfaj_pkg::AREA_W;
  localparam int NL    = qfaj_pkg::NPT;
  localparam int XW    = qfaj_pkg::RAD_W;
  localparam int REM_W = NS + 1;
  localparam int TW    = NS + 3;

  qfaj_pkg::qfaj_ctl_t ctl_r  [NS];
  logic [XW-1:0]       x_r    [NS][NL];
  logic [REM_W-1:0]    rem_r  [NS][NL];
  logic [NS-1:0]       root_r [NS][NL];

  // One root bit per stage, most significant first, restoring recurrence.
  for (genvar j = 0; j < NS; j++) begin : g_stage
    qfaj_pkg::qfaj_ctl_t ctl_src;
    logic [XW-1:0]       x_src    [NL];
    logic [REM_W-1:0]    rem_src  [NL];
    logic [NS-1:0]       root_src [NL];
    logic [XW-1:0]       x_nxt    [NL];
    logic [REM_W-1:0]    rem_nxt  [NL];
    logic [NS-1:0]       root_nxt [NL];

    if (j == 0) begin : g_first
      assign ctl_src = in_ctl;
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign x_src[l]    = in_rad[l];
        assign rem_src[l]  = '0;
        assign root_src[l] = '0;
      end
    end else begin : g_next
      assign ctl_src = ctl_r[j-1];
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign x_src[l]    = x_r[j-1][l];
        assign rem_src[l]  = rem_r[j-1][l];
        assign root_src[l] = root_r[j-1][l];
      end
    end

    always_comb begin
      logic [TW-1:0] cur;
      logic [TW-1:0] trial;
      for (int l = 0; l < NL; l++) begin
        cur   = {rem_src[l], x_src[l][XW-1 -: 2]};
        trial = {1'b0, root_src[l], 2'b01};
        x_nxt[l] = {x_src[l][XW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_nxt[l]  = REM_W'(cur - trial);
          root_nxt[l] = {root_src[l][NS-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = REM_W'(cur);
          root_nxt[l] = {root_src[l][NS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= ctl_src;
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < NL; l++) begin
        x_r[j][l]    <= x_nxt[l];
        rem_r[j][l]  <= rem_nxt[l];
        root_r[j][l] <= root_nxt[l];
      end
    end
  end

  assign out_ctl = ctl_r[NS-1];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_root[l] = root_r[NS-1][l];
  end

endmodule

@@ sv/quad_face_area_jacobian.sv @@
// Differential area of a bilinear four-node face at the four 2x2 Gauss points.
// One face is taken per clock whenever start is high; busy is always low, so the
// block never refuses a transfer. Each face produces one result transfer through
// eight arithmetic stages (edge sums, Gauss scaling, Jacobian rounding, minor
// products, minor magnitudes, split squares, sum of squares, scaling), a
// 48-stage square root that settles one area bit per stage, and the output
// register. The result is shown for one cycle under out_valid and cannot be
// held off, so the receiver must take it then. Writing cfg_data with cfg_we
// changes the Gauss coordinate; write it only while no face is in flight.
// Areas that reach 2^48 units are clipped to all ones and raise out_saturated.
module quad_face_area_jacobian #(
  parameter int COORD_WIDTH = qfaj_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = qfaj_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_node0_x,
  input  logic signed [COORD_WIDTH-1:0]       in_node1_x,
  input  logic signed [COORD_WIDTH-1:0]       in_node2_x,
  input  logic signed [COORD_WIDTH-1:0]       in_node3_x,
  input  logic signed [COORD_WIDTH-1:0]       in_node0_y,
  input  logic signed [COORD_WIDTH-1:0]       in_node1_y,
  input  logic signed [COORD_WIDTH-1:0]       in_node2_y,
  input  logic signed [COORD_WIDTH-1:0]       in_node3_y,
  input  logic signed [COORD_WIDTH-1:0]       in_node0_z,
  input  logic signed [COORD_WIDTH-1:0]       in_node1_z,
  input  logic signed [COORD_WIDTH-1:0]       in_node2_z,
  input  logic signed [COORD_WIDTH-1:0]       in_node3_z,
  input  logic                                cfg_we,
  input  logic [qfaj_pkg::GAUSS_W-1:0]        cfg_data,
  output logic                                out_valid,
  output logic [qfaj_pkg::AREA_W-1:0]         out_area_point0,
  output logic [qfaj_pkg::AREA_W-1:0]         out_area_point1,
  output logic [qfaj_pkg::AREA_W-1:0]         out_area_point2,
  output logic [qfaj_pkg::AREA_W-1:0]         out_area_point3,
  output logic                                out_saturated
);

  localparam int NPT  = qfaj_pkg::NPT;
  localparam int NC   = qfaj_pkg::NCRD;
  localparam int GW   = qfaj_pkg::GAUSS_W;
  localparam int SW1  = COORD_WIDTH + 2;
  localparam int GBW  = SW1 + GW + 1;
  localparam int RW   = COORD_WIDTH + 19;
  localparam int JW   = COORD_WIDTH + 3;
  localparam int PW   = 2 * JW;
  localparam int HW   = PW / 2;
  localparam int UW   = PW - HW;
  localparam int SW   = 2 * PW + 2;
  localparam int SH2  = 2 * (qfaj_pkg::AREA_FRAC - 2 * FRAC_BITS);
  localparam int SHL  = (SH2 > 0) ? SH2 : 0;
  localparam int SHR  = (SH2 < 0) ? -SH2 : 0;
  localparam int EW   = SW + SHL + qfaj_pkg::RAD_W;
  localparam int RADW = qfaj_pkg::RAD_W;
  localparam int AW   = qfaj_pkg::AREA_W;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Gauss coordinate register.
  logic [GW-1:0] gauss_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gauss_r <= qfaj_pkg::GAUSS_RESET;
    end else if (cfg_we) begin
      gauss_r <= cfg_data;
    end
  end

  logic signed [COORD_WIDTH-1:0] xin [NC][4];
  assign xin[0][0] = in_node0_x;
  assign xin[0][1] = in_node1_x;
  assign xin[0][2] = in_node2_x;
  assign xin[0][3] = in_node3_x;
  assign xin[1][0] = in_node0_y;
  assign xin[1][1] = in_node1_y;
  assign xin[1][2] = in_node2_y;
  assign xin[1][3] = in_node3_y;
  assign xin[2][0] = in_node0_z;
  assign xin[2][1] = in_node1_z;
  assign xin[2][2] = in_node2_z;
  assign xin[2][3] = in_node3_z;

  // Stage 1: edge sums. The r and s derivatives reduce to 2^15*A +- g*B and
  // 2^15*C +- g*B, with A, B and C signed sums of the node coordinates.
  logic                  v1_r;
  logic signed [SW1-1:0] sa_r [NC];
  logic signed [SW1-1:0] sb_r [NC];
  logic signed [SW1-1:0] sc_r [NC];
  logic signed [SW1-1:0] sa_nxt [NC];
  logic signed [SW1-1:0] sb_nxt [NC];
  logic signed [SW1-1:0] sc_nxt [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sa_nxt[c] = -SW1'(xin[c][0]) + SW1'(xin[c][1]) + SW1'(xin[c][2]) - SW1'(xin[c][3]);
      sb_nxt[c] =  SW1'(xin[c][0]) - SW1'(xin[c][1]) + SW1'(xin[c][2]) - SW1'(xin[c][3]);
      sc_nxt[c] = -SW1'(xin[c][0]) - SW1'(xin[c][1]) + SW1'(xin[c][2]) + SW1'(xin[c][3]);
    end
  end

  // Stage 2: scale the twist term by the Gauss coordinate.
  logic                  v2_r;
  logic signed [SW1-1:0] a2_r  [NC];
  logic signed [SW1-1:0] c2_r  [NC];
  logic signed [GBW-1:0] gb_r  [NC];
  logic signed [GW:0]    gauss_s;
  assign gauss_s = {1'b0, gauss_r};

  // Stage 3: Jacobian entries, rounded to nearest with ties upward.
  logic                 v3_r;
  logic signed [JW-1:0] jac_r   [NPT][NC][2];
  logic signed [JW-1:0] jac_nxt [NPT][NC][2];

  always_comb begin
    logic signed [RW-1:0] base_r;
    logic signed [RW-1:0] base_s;
    logic signed [RW-1:0] twist;
    logic signed [RW-1:0] raw_r;
    logic signed [RW-1:0] raw_s;
    logic signed [RW-1:0] bias;
    bias = RW'(1) <<< (qfaj_pkg::JAC_SHIFT - 1);
    for (int k = 0; k < NPT; k++) begin
      for (int c = 0; c < NC; c++) begin
        base_r = RW'(a2_r[c]) <<< qfaj_pkg::HALF_LSB;
        base_s = RW'(c2_r[c]) <<< qfaj_pkg::HALF_LSB;
        twist  = RW'(gb_r[c]);
        raw_r  = qfaj_pkg::PT_S_NEG[k] ? base_r - twist : base_r + twist;
        raw_s  = qfaj_pkg::PT_R_NEG[k] ? base_s - twist : base_s + twist;
        raw_r  = (raw_r + bias) >>> qfaj_pkg::JAC_SHIFT;
        raw_s  = (raw_s + bias) >>> qfaj_pkg::JAC_SHIFT;
        jac_nxt[k][c][0] = raw_r[JW-1:0];
        jac_nxt[k][c][1] = raw_s[JW-1:0];
      end
    end
  end

  // Stage 4: the two cross products of each 2x2 minor.
  logic                 v4_r;
  logic signed [PW-1:0] pp_r [NPT][NC];
  logic signed [PW-1:0] pq_r [NPT][NC];

  // Stage 5: minor magnitudes.
  logic          v5_r;
  logic [PW-1:0] mag_r   [NPT][NC];
  logic [PW-1:0] mag_nxt [NPT][NC];

  always_comb begin
    logic signed [PW:0] diff;
    for (int k = 0; k < NPT; k++) begin
      for (int m = 0; m < NC; m++) begin
        diff = (PW+1)'(pp_r[k][m]) - (PW+1)'(pq_r[k][m]);
        if (diff[PW]) begin
          diff = -diff;
        end
        mag_nxt[k][m] = diff[PW-1:0];
      end
    end
  end

  // Stage 6: squares split into high and low halves.
  logic              v6_r;
  logic [2*UW-1:0]   hh_r [NPT][NC];
  logic [UW+HW-1:0]  hl_r [NPT][NC];
  logic [2*HW-1:0]   ll_r [NPT][NC];

  // Stage 7: sum of squared minors.
  logic          v7_r;
  logic [SW-1:0] ss_r   [NPT];
  logic [SW-1:0] ss_nxt [NPT];

  always_comb begin
    logic [SW-1:0] acc;
    for (int k = 0; k < NPT; k++) begin
      acc = '0;
      for (int m = 0; m < NC; m++) begin
        acc = acc + (SW'(hh_r[k][m]) << (2 * HW)) + (SW'(hl_r[k][m]) << (HW + 1))
            + SW'(ll_r[k][m]);
      end
      ss_nxt[k] = acc;
    end
  end

  // Stage 8: scale to the area format and detect overflow.
  qfaj_pkg::qfaj_ctl_t ctl8_r;
  logic [RADW-1:0]     rad_r   [NPT];
  logic [RADW-1:0]     rad_nxt [NPT];
  logic [NPT-1:0]      sat_nxt;

  always_comb begin
    logic [EW-1:0] sc;
    for (int k = 0; k < NPT; k++) begin
      sc = (EW'(ss_r[k]) << SHL) >> SHR;
      sat_nxt[k] = |sc[EW-1:RADW];
      rad_nxt[k] = sc[RADW-1:0];
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      v7_r   <= 1'b0;
      ctl8_r <= '0;
    end else begin
      v1_r       <= start && !busy;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      v4_r       <= v3_r;
      v5_r       <= v4_r;
      v6_r       <= v5_r;
      v7_r       <= v6_r;
      ctl8_r.vld <= v7_r;
      ctl8_r.sat <= sat_nxt;
    end
  end

  // Data of the arithmetic stages.
  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      sa_r[c] <= sa_nxt[c];
      sb_r[c] <= sb_nxt[c];
      sc_r[c] <= sc_nxt[c];
      a2_r[c] <= sa_r[c];
      c2_r[c] <= sc_r[c];
      gb_r[c] <= GBW'(gauss_s) * GBW'(sb_r[c]);
    end
    for (int k = 0; k < NPT; k++) begin
      for (int c = 0; c < NC; c++) begin
        jac_r[k][c][0] <= jac_nxt[k][c][0];
        jac_r[k][c][1] <= jac_nxt[k][c][1];
      end
      for (int m = 0; m < NC; m++) begin
        pp_r[k][m] <= PW'(jac_r[k][qfaj_pkg::minor_first(m)][0])
                    * PW'(jac_r[k][qfaj_pkg::minor_second(m)][1]);
        pq_r[k][m] <= PW'(jac_r[k][qfaj_pkg::minor_first(m)][1])
                    * PW'(jac_r[k][qfaj_pkg::minor_second(m)][0]);
        mag_r[k][m] <= mag_nxt[k][m];
        hh_r[k][m]  <= (2*UW)'(mag_r[k][m][PW-1:HW]) * (2*UW)'(mag_r[k][m][PW-1:HW]);
        hl_r[k][m]  <= (UW+HW)'(mag_r[k][m][PW-1:HW]) * (UW+HW)'(mag_r[k][m][HW-1:0]);
        ll_r[k][m]  <= (2*HW)'(mag_r[k][m][HW-1:0]) * (2*HW)'(mag_r[k][m][HW-1:0]);
      end
      ss_r[k]  <= ss_nxt[k];
      rad_r[k] <= rad_nxt[k];
    end
  end

  // Square root, one bit per stage.
  qfaj_pkg::qfaj_ctl_t sq_ctl;
  logic [AW-1:0]       sq_root [NPT];

  qfaj_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (ctl8_r),
    .in_rad   (rad_r),
    .out_ctl  (sq_ctl),
    .out_root (sq_root)
  );

  // Output register: clip saturated points.
  logic          out_valid_r;
  logic          sat_r;
  logic [AW-1:0] area_r [NPT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= |sq_ctl.sat;
    for (int k = 0; k < NPT; k++) begin
      area_r[k] <= sq_ctl.sat[k] ? {AW{1'b1}} : sq_root[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_saturated   = sat_r;
  assign out_area_point0 = area_r[0];
  assign out_area_point1 = area_r[1];
  assign out_area_point2 = area_r[2];
  assign out_area_point3 = area_r[3];

endmodule

@@ sv/qfaj_checker.sv @@
`include "quad_face_area_jacobian_assert.svh"

module qfaj_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_saturated,
  input logic [qfaj_pkg::AREA_W-1:0]   out_area_point0,
  input logic [qfaj_pkg::AREA_W-1:0]   out_area_point1,
  input logic [qfaj_pkg::AREA_W-1:0]   out_area_point2,
  input logic [qfaj_pkg::AREA_W-1:0]   out_area_point3
);

  localparam logic [qfaj_pkg::AREA_W-1:0] AREA_MAX = {qfaj_pkg::AREA_W{1'b1}};

  // The block never refuses a transfer.
  `QFAJ_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

  // Every result comes from a face that was started earlier.
  `QFAJ_ASSERT_IMP(a_latency, out_valid, $past(start, qfaj_pkg::LATENCY), "result without start")

  // A saturated result shows at least one clipped area.
  `QFAJ_ASSERT_IMP(a_sat_clip, out_valid && out_saturated,
    out_area_point0 == AREA_MAX || out_area_point1 == AREA_MAX ||
    out_area_point2 == AREA_MAX || out_area_point3 == AREA_MAX, "saturated without clip")

  // Reset flushes the results in flight.
  `QFAJ_ASSERT_NEXT(a_reset_flush, !rst_n, !out_valid, "result after reset")

endmodule

bind quad_face_area_jacobian qfaj_checker u_qfaj_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_saturated   (out_saturated),
  .out_area_point0 (out_area_point0),
  .out_area_point1 (out_area_point1),
  .out_area_point2 (out_area_point2),
  .out_area_point3 (out_area_point3)
);

@@ tb/sv/quad_face_area_jacobian_checker.sv @@
module quad_face_area_jacobian_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    busy,
  input  logic [11:0][qfaj_pkg::COORD_WIDTH_DEF-1:0] coords,
  input  logic                                    cfg_we,
  input  logic [qfaj_pkg::GAUSS_W-1:0]            cfg_data,
  input  logic                                    out_valid,
  input  logic [qfaj_pkg::AREA_W-1:0]             out_area_point0,
  input  logic [qfaj_pkg::AREA_W-1:0]             out_area_point1,
  input  logic [qfaj_pkg::AREA_W-1:0]             out_area_point2,
  input  logic [qfaj_pkg::AREA_W-1:0]             out_area_point3,
  input  logic                                    out_saturated,
  output int                                      fail_count,
  output int                                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import qfaj_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [AREA_W-1:0] AREA_CLIP = '1;

  // Node signs in r and s; point k uses the same sign pattern.
  localparam int SIGN_R [4] = '{-1, 1, 1, -1};
  localparam int SIGN_S [4] = '{-1, -1, 1, 1};

  typedef struct {
    logic [AREA_W-1:0] area [NPT];
    logic              sat;
  } face_areas_t;

  logic [GAUSS_W-1:0] gauss_q;
  face_areas_t        area_queue [$];

  // Integer square root of a 128-bit value, rounded down.
  function automatic logic [63:0] isqrt128(input logic [127:0] s);
    logic [63:0]  r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'b0, r | (64'd1 << b)};
      if (c * c <= s) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  // Differential areas of one face at the four Gauss points.
  function automatic face_areas_t face_areas(input logic [11:0][CW-1:0] crd,
                                             input logic [GAUSS_W-1:0] g);
    face_areas_t          res;
    longint               jac [3][2];
    longint               raw;
    longint               w;
    int                   gi;
    logic signed [127:0]  ja [3][2];
    logic signed [127:0]  m0, m1, m2;
    logic [127:0]         sum;
    logic [63:0]          r;
    gi = int'(g);
    res.sat = 1'b0;
    for (int k = 0; k < NPT; k++) begin
      for (int c = 0; c < NCRD; c++) begin
        for (int d = 0; d < 2; d++) begin
          raw = 0;
          for (int i = 0; i < 4; i++) begin
            if (d == 0) w = SIGN_R[i] * (32768 + SIGN_S[i] * SIGN_S[k] * gi);
            else w = SIGN_S[i] * (32768 + SIGN_R[i] * SIGN_R[k] * gi);
            raw += w * longint'($signed(crd[c*4+i]));
          end
          // Round to nearest with ties toward plus infinity.
          jac[c][d] = (raw + 65536) >>> JAC_SHIFT;
          ja[c][d] = jac[c][d];
        end
      end
      m0 = ja[0][0] * ja[1][1] - ja[0][1] * ja[1][0];
      m1 = ja[1][0] * ja[2][1] - ja[1][1] * ja[2][0];
      m2 = ja[0][0] * ja[2][1] - ja[0][1] * ja[2][0];
      sum = m0 * m0 + m1 * m1 + m2 * m2;
      r = isqrt128(sum);
      if (r > {16'b0, AREA_CLIP}) begin
        res.area[k] = AREA_CLIP;
        res.sat = 1'b1;
      end else begin
        res.area[k] = r[AREA_W-1:0];
      end
    end
    return res;
  endfunction

  assign pending_count = area_queue.size();

  // Track the register, queue predictions on input transfers, check result transfers.
  always @(posedge clk) begin
    face_areas_t exp_r;
    logic [AREA_W-1:0] got [NPT];
    int errs;
    errs = 0;
    if (!rst_n) begin
      gauss_q <= GAUSS_RESET;
      area_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) gauss_q <= cfg_data;
      if (start && !busy) area_queue.push_back(face_areas(coords, gauss_q));
      if (out_valid) begin
        if (area_queue.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errs++;
        end else begin
          exp_r = area_queue.pop_front();
          got = '{out_area_point0, out_area_point1, out_area_point2, out_area_point3};
          for (int k = 0; k < NPT; k++) begin
            if (got[k] !== exp_r.area[k]) begin
              $display("%0t: area_point%0d expected %h actual %h", $time, k,
                       exp_r.area[k], got[k]);
              errs++;
            end
          end
          if (out_saturated !== exp_r.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
                     out_saturated);
            errs++;
          end
        end
      end
      // One update of the count per cycle, however many fields differ.
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

@@ tb/sv/quad_face_area_jacobian_tb.sv @@
module quad_face_area_jacobian_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qfaj_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [GAUSS_W-1:0] cfg_data = '0;
  logic [11:0][CW-1:0] coords = '0;
  logic out_valid;
  logic [AREA_W-1:0] out_area_point0, out_area_point1, out_area_point2, out_area_point3;
  logic out_saturated;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  quad_face_area_jacobian i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_node0_x(coords[0]), .in_node1_x(coords[1]),
    .in_node2_x(coords[2]), .in_node3_x(coords[3]),
    .in_node0_y(coords[4]), .in_node1_y(coords[5]),
    .in_node2_y(coords[6]), .in_node3_y(coords[7]),
    .in_node0_z(coords[8]), .in_node1_z(coords[9]),
    .in_node2_z(coords[10]), .in_node3_z(coords[11]),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_area_point0(out_area_point0), .out_area_point1(out_area_point1),
    .out_area_point2(out_area_point2), .out_area_point3(out_area_point3),
    .out_saturated(out_saturated)
  );

  quad_face_area_jacobian_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .coords(coords),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_area_point0(out_area_point0), .out_area_point1(out_area_point1),
    .out_area_point2(out_area_point2), .out_area_point3(out_area_point3),
    .out_saturated(out_saturated), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("quad_face_area_jacobian regression: fail");
      $finish;
    end
  end

  // One coordinate: full range, extremes, zero, small or moderate values.
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return CW'($urandom);
      3:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      4, 5:    return CW'($signed($urandom_range(0, 16383)) - 8192);
      6:       return '0;
      default: return CW'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  // Gap after a transfer: none while no_gaps is set, else mostly none or short, a few long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one face and hold it until the transfer happens.
  task automatic send_face(input logic [11:0][CW-1:0] face);
    int gap;
    coords <= face;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the pipeline drain completely.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Change the Gauss coordinate with nothing in flight.
  task automatic write_gauss(input logic [GAUSS_W-1:0] g);
    drain();
    cfg_data <= g;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A plausible face: four nodes around a center with random spread.
  function automatic logic [11:0][CW-1:0] shaped_face();
    logic [11:0][CW-1:0] f;
    int cen, spread;
    for (int c = 0; c < 3; c++) begin
      cen = $signed($urandom_range(0, 4194303)) - 2097152;
      spread = $urandom_range(0, 3) == 0 ? 3000000 : 20000;
      for (int i = 0; i < 4; i++)
        f[c*4+i] = CW'(cen + $signed($urandom_range(0, 2*spread)) - spread);
    end
    return f;
  endfunction

  task automatic random_faces(input int n);
    logic [11:0][CW-1:0] f;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 1)) f = shaped_face();
      else for (int i = 0; i < 12; i++) f[i] = pick_coord();
      send_face(f);
    end
  endtask

  initial begin
    logic [11:0][CW-1:0] f;
    logic [GAUSS_W-1:0] gset [6];
    gset = '{16'd0, 16'd32768, 16'hFFFF, 16'd18919, 16'd1, 16'd0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed faces at the reset Gauss coordinate.
    send_face('0);
    send_face({12{C_MAX}});
    send_face({12{C_MIN}});
    send_face({12{CW'(-1)}});
    // Square with corners at the coordinate extremes, tilted in z.
    f = {C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
         C_MIN, C_MAX, C_MAX, C_MIN};
    send_face(f);
    // Unit square in the xy plane.
    f = '0;
    f[1] = CW'(4096); f[2] = CW'(4096); f[6] = CW'(4096); f[7] = CW'(4096);
    send_face(f);
    // Alternating extremes over every field.
    for (int i = 0; i < 12; i++) f[i] = i[0] ? C_MAX : C_MIN;
    send_face(f);
    for (int i = 0; i < 12; i++) f[i] = i[0] ? C_MIN : C_MAX;
    send_face(f);
    random_faces(120);

    // Sweep the Gauss coordinate through its extremes and some random values.
    for (int p = 0; p < 8; p++) begin
      write_gauss(p < 6 ? gset[p] : GAUSS_W'($urandom));
      no_gaps = (p == 2 || p == 5);
      f = {C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
           C_MIN, C_MAX, C_MAX, C_MIN};
      send_face(f);
      send_face({12{C_MAX}});
      random_faces(75);
    end
    no_gaps = 1'b0;
    write_gauss(GAUSS_W'($urandom_range(0, 32768)));
    random_faces(20);

    drain();
    if (fail_count == 0) begin
      $display("quad_face_area_jacobian regression: pass");
    end else begin
      $display("quad_face_area_jacobian regression: fail");
    end
    $finish;
  end

endmodule

@@ quad_face_area_jacobian.f @@
+incdir+sv
sv/qfaj_pkg.sv
sv/qfaj_isqrt.sv
sv/quad_face_area_jacobian.sv
sv/qfaj_checker.sv
tb/sv/quad_face_area_jacobian_checker.sv
tb/sv/quad_face_area_jacobian_tb.sv
